// ----- design/mbg_pkg.sv -----
// Shared types, constants and helpers of the backtracking maze generator.
package mbg_pkg;

    // Grid limits
    localparam int MAX_SIDE  = 64;
    localparam int MAX_CELLS = 4096;

    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);   // holds a side length
    localparam int COORD_W   = $clog2(MAX_SIDE);       // column or row number
    localparam int IDX_W     = $clog2(MAX_CELLS);      // cell number
    localparam int CNT_W     = IDX_W + 1;              // cell or stack count
    localparam int RND_W     = 15;
    localparam int WALL_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam int DIV_CNT_W = $clog2(IDX_W + 1);

    // Wall bits
    localparam logic [WALL_W-1:0] WALL_N   = 4'h1;
    localparam logic [WALL_W-1:0] WALL_E   = 4'h2;
    localparam logic [WALL_W-1:0] WALL_S   = 4'h4;
    localparam logic [WALL_W-1:0] WALL_W_B = 4'h8;
    localparam logic [WALL_W-1:0] WALL_ALL = 4'hF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Neighbour directions, in test order
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_CARVE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [RND_W-1:0]   random_value;
        logic [IDX_W-1:0]   cell_index;
    } t_cmd;

    typedef struct packed {
        logic [WALL_W-1:0]  walls;
        logic [IDX_W-1:0]   position;
        logic               finished;
        logic               fault;
    } t_res;

    // Value mod 3: base-4 digits sum to the same residue, twice over
    function automatic logic [1:0] rnd_mod3(input logic [RND_W-1:0] v);
        logic [15:0] v16;
        logic [4:0]  s;
        logic [2:0]  t;
        v16 = {1'b0, v};
        s   = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, v16[2*i +: 2]};
        end
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ----- design/maze_backtracker_generator.sv -----
// Recursive-backtracker maze generator around a wall memory and a cell stack.
//
// Usage: present a command beat on i_cmd and raise start; it is taken at a
// clock edge with start high and busy low. Every command gives one result
// beat on o_res, flagged by o_strobe for exactly one cycle; there is no
// back-pressure, the receiver must take it then.
// Opcodes: clear (all walls up, restart at cell 0), carve (one move of the
// generator), read (walls of one cell), no-op (walls 0, no fault).
// A carve runs the coordinate divider first when the width changed, and a
// stack read, the divider and a fresh neighbour scan for each backtracking
// pop, and it cuts the closing openings when the last cell is reached; read,
// no-op and a carve after the finish only read the result cell. A clear
// sweeps the wall memory one entry per cycle through its single write port.
// One command is in flight at a time; the next is taken in the strobe cycle.
// Reset (synchronous, active low) runs the same sweep with busy high and
// no result; configuration writes (i_cfg_we) are taken at any time, one
// register per edge, and must only be made while no command runs.
module maze_backtracker_generator
    import mbg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    output logic                 o_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_LOOP, S_DIV, S_SCAN, S_DECIDE, S_POP_RD, S_POP_DAT,
        S_CUR_RD, S_CUR_WR, S_NB_WR, S_FIN0_RD, S_FIN0_WR, S_FIN1_RD,
        S_FIN1_WR, S_RES_RD, S_RES_DAT
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_cfg_w, r_cfg_h;
    logic [IDX_W-1:0]      r_cur;
    logic [COORD_W-1:0]    r_x, r_y;
    logic                  r_stale;
    logic [CNT_W-1:0]      r_sp, r_visited;
    logic                  r_done;
    t_opcode               r_op;
    logic [RND_W-1:0]      r_rnd;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_fault;
    logic [2:0]            r_k;
    logic [3:0]            r_free;
    logic [1:0]            r_dir;
    logic                  r_multi;
    logic [IDX_W-1:0]      r_sweep;
    logic                  r_reply;
    logic [IDX_W-1:0]      r_div_q;
    logic [SIDE_W-1:0]     r_div_r;
    logic [DIV_CNT_W-1:0]  r_div_n;
    logic                  r_strobe;
    t_res                  r_res;

    // Memories and their ports
    logic [WALL_W-1:0]     wall_mem [MAX_CELLS];
    logic [IDX_W-1:0]      stk_mem  [MAX_CELLS];
    logic [WALL_W-1:0]     r_wall_q;
    logic [IDX_W-1:0]      r_stk_q;
    logic                  w_we, s_we;
    logic [IDX_W-1:0]      w_wa, w_ra, s_wa, s_ra, s_wd;
    logic [WALL_W-1:0]     w_wd;

    // Grid size from the registers, clamped to the legal range
    logic [SIDE_W-1:0]     c_w, c_h;
    logic [2*SIDE_W-1:0]   c_prod;
    logic [CNT_W-1:0]      c_cells;
    logic [IDX_W-1:0]      c_w_ext, c_last;

    always_comb begin
        if (r_cfg_w < CFG_W'(2)) begin
            c_w = SIDE_W'(2);
        end else if (r_cfg_w > CFG_W'(MAX_SIDE)) begin
            c_w = SIDE_W'(MAX_SIDE);
        end else begin
            c_w = SIDE_W'(r_cfg_w);
        end
        if (r_cfg_h < CFG_W'(2)) begin
            c_h = SIDE_W'(2);
        end else if (r_cfg_h > CFG_W'(MAX_SIDE)) begin
            c_h = SIDE_W'(MAX_SIDE);
        end else begin
            c_h = SIDE_W'(r_cfg_h);
        end
    end

    assign c_prod  = c_w * c_h;
    assign c_cells = c_prod[CNT_W-1:0];
    assign c_w_ext = IDX_W'(c_w);
    assign c_last  = IDX_W'(c_cells - CNT_W'(1));

    // Neighbour addresses and bounds, right/left/up/down
    logic [IDX_W-1:0] nb_addr [4];
    logic [3:0]       nb_ok;

    assign nb_addr[DIR_RIGHT] = r_cur + IDX_W'(1);
    assign nb_addr[DIR_LEFT]  = r_cur - IDX_W'(1);
    assign nb_addr[DIR_UP]    = r_cur - c_w_ext;
    assign nb_addr[DIR_DOWN]  = r_cur + c_w_ext;
    assign nb_ok[DIR_RIGHT]   = (SIDE_W'(r_x) + SIDE_W'(1)) < c_w;
    assign nb_ok[DIR_LEFT]    = r_x != '0;
    assign nb_ok[DIR_UP]      = r_y != '0;
    assign nb_ok[DIR_DOWN]    = (SIDE_W'(r_y) + SIDE_W'(1)) < c_h;

    logic [1:0] k_prev;
    assign k_prev = 2'(r_k - 3'd1);

    // Choice among the free neighbours
    logic [2:0] free_n;
    logic [1:0] sel, pick;
    logic [2:0] seen;
    logic       found;

    always_comb begin
        free_n = 3'(r_free[0]) + 3'(r_free[1]) + 3'(r_free[2]) + 3'(r_free[3]);
        case (free_n)
            3'd2:    sel = {1'b0, r_rnd[0]};
            3'd3:    sel = rnd_mod3(r_rnd);
            3'd4:    sel = r_rnd[1:0];
            default: sel = 2'd0;
        endcase
        pick  = DIR_RIGHT;
        seen  = '0;
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_free[i] && !found && seen == {1'b0, sel}) begin
                pick  = 2'(i);
                found = 1'b1;
            end
            if (r_free[i]) begin
                seen = seen + 3'd1;
            end
        end
    end

    // Walls removed on each side of a move
    logic [WALL_W-1:0] cur_mask, nb_mask;

    always_comb begin
        case (r_dir)
            DIR_RIGHT: begin cur_mask = WALL_E;   nb_mask = WALL_W_B; end
            DIR_LEFT:  begin cur_mask = WALL_W_B; nb_mask = WALL_E;   end
            DIR_UP:    begin cur_mask = WALL_N;   nb_mask = WALL_S;   end
            default:   begin cur_mask = WALL_S;   nb_mask = WALL_N;   end
        endcase
    end

    // One restoring division step: cell number by row width
    logic [SIDE_W-1:0] div_trial;
    logic [SIDE_W-1:0] n_div_r;
    logic [IDX_W-1:0]  n_div_q;

    always_comb begin
        div_trial = {r_div_r[SIDE_W-2:0], r_div_q[IDX_W-1]};
        if (div_trial >= c_w) begin
            n_div_r = div_trial - c_w;
            n_div_q = {r_div_q[IDX_W-2:0], 1'b1};
        end else begin
            n_div_r = div_trial;
            n_div_q = {r_div_q[IDX_W-2:0], 1'b0};
        end
    end

    // Result of the current command
    logic [IDX_W-1:0] res_addr;
    logic             res_oob;
    logic             push_ok;

    assign res_addr = (r_op == OP_READ) ? r_idx : r_cur;
    assign res_oob  = CNT_W'(res_addr) >= c_cells;
    assign push_ok  = r_multi && (r_sp < CNT_W'(MAX_CELLS));

    // Memory port control
    always_comb begin
        w_we = 1'b0;
        w_wa = r_cur;
        w_wd = WALL_ALL;
        w_ra = res_addr;
        s_we = 1'b0;
        s_wa = r_sp[IDX_W-1:0];
        s_wd = r_cur;
        s_ra = IDX_W'(r_sp - CNT_W'(1));
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_wa = r_sweep;
            end
            S_SCAN: begin
                w_ra = nb_addr[r_k[1:0]];
            end
            S_CUR_WR: begin
                w_we = 1'b1;
                w_wd = r_wall_q & ~cur_mask;
            end
            S_NB_WR: begin
                w_we = 1'b1;
                w_wa = nb_addr[r_dir];
                w_wd = WALL_ALL & ~nb_mask;
                s_we = push_ok;
            end
            S_FIN0_RD: begin
                w_ra = '0;
            end
            S_FIN0_WR: begin
                w_we = 1'b1;
                w_wa = '0;
                w_wd = r_wall_q & ~WALL_N;
            end
            S_FIN1_RD: begin
                w_ra = c_last;
            end
            S_FIN1_WR: begin
                w_we = 1'b1;
                w_wa = c_last;
                w_wd = r_wall_q & ~WALL_S;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Wall memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wall_mem[w_wa] <= w_wd;
        end
        r_wall_q <= wall_mem[w_ra];
    end

    // Cell stack memory
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            stk_mem[s_wa] <= s_wd;
        end
        r_stk_q <= stk_mem[s_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_sweep   <= '0;
            r_reply   <= 1'b0;
            r_strobe  <= 1'b0;
            r_cfg_w   <= CFG_W'(51);
            r_cfg_h   <= CFG_W'(51);
            r_cur     <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_stale   <= 1'b0;
            r_sp      <= '0;
            r_visited <= CNT_W'(1);
            r_done    <= 1'b0;
            r_fault   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_cmd.opcode;
                        r_rnd   <= i_cmd.random_value;
                        r_idx   <= i_cmd.cell_index;
                        r_fault <= 1'b0;
                        case (i_cmd.opcode)
                            OP_CLEAR: begin
                                r_sweep <= '0;
                                r_reply <= 1'b1;
                                r_state <= S_CLR;
                            end
                            OP_CARVE: begin
                                if (r_done) begin
                                    r_state <= S_RES_RD;
                                end else if (r_visited >= c_cells) begin
                                    r_state <= S_FIN0_RD;
                                end else begin
                                    r_state <= S_LOOP;
                                end
                            end
                            default: begin
                                r_state <= S_RES_RD;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_sweep <= r_sweep + IDX_W'(1);
                    if (r_sweep == '1) begin
                        r_cur     <= '0;
                        r_x       <= '0;
                        r_y       <= '0;
                        r_stale   <= 1'b0;
                        r_sp      <= '0;
                        r_visited <= CNT_W'(1);
                        r_done    <= 1'b0;
                        r_state   <= r_reply ? S_RES_RD : S_IDLE;
                    end
                end
                S_LOOP: begin
                    if (CNT_W'(r_cur) >= c_cells) begin
                        r_fault <= 1'b1;
                        r_state <= S_RES_RD;
                    end else if (r_stale) begin
                        r_div_q <= r_cur;
                        r_div_r <= '0;
                        r_div_n <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_k     <= '0;
                        r_free  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_DIV: begin
                    r_div_q <= n_div_q;
                    r_div_r <= n_div_r;
                    r_div_n <= r_div_n + DIV_CNT_W'(1);
                    if (r_div_n == DIV_CNT_W'(IDX_W - 1)) begin
                        r_x     <= n_div_r[COORD_W-1:0];
                        r_y     <= n_div_q[COORD_W-1:0];
                        r_stale <= 1'b0;
                        r_k     <= '0;
                        r_free  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read for direction k goes out, data of k-1 comes back
                    if (r_k != '0) begin
                        r_free[k_prev] <= nb_ok[k_prev] && (r_wall_q == WALL_ALL);
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (free_n == '0) begin
                        if (r_sp == '0) begin
                            r_fault <= 1'b1;
                            r_state <= S_RES_RD;
                        end else begin
                            r_state <= S_POP_RD;
                        end
                    end else begin
                        r_dir   <= pick;
                        r_multi <= free_n > 3'd1;
                        r_state <= S_CUR_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_DAT;
                end
                S_POP_DAT: begin
                    r_cur   <= r_stk_q;
                    r_sp    <= r_sp - CNT_W'(1);
                    r_stale <= 1'b1;
                    r_state <= S_LOOP;
                end
                S_CUR_RD: begin
                    r_state <= S_CUR_WR;
                end
                S_CUR_WR: begin
                    r_state <= S_NB_WR;
                end
                S_NB_WR: begin
                    if (push_ok) begin
                        r_sp <= r_sp + CNT_W'(1);
                    end
                    r_cur     <= nb_addr[r_dir];
                    r_visited <= r_visited + CNT_W'(1);
                    case (r_dir)
                        DIR_RIGHT: r_x <= r_x + COORD_W'(1);
                        DIR_LEFT:  r_x <= r_x - COORD_W'(1);
                        DIR_UP:    r_y <= r_y - COORD_W'(1);
                        default:   r_y <= r_y + COORD_W'(1);
                    endcase
                    if ((r_visited + CNT_W'(1)) >= c_cells) begin
                        r_state <= S_FIN0_RD;
                    end else begin
                        r_state <= S_RES_RD;
                    end
                end
                S_FIN0_RD: begin
                    r_state <= S_FIN0_WR;
                end
                S_FIN0_WR: begin
                    r_state <= S_FIN1_RD;
                end
                S_FIN1_RD: begin
                    r_state <= S_FIN1_WR;
                end
                S_FIN1_WR: begin
                    r_done  <= 1'b1;
                    r_state <= S_RES_RD;
                end
                S_RES_RD: begin
                    r_state <= S_RES_DAT;
                end
                S_RES_DAT: begin
                    r_res.walls    <= (r_op == OP_NOP || res_oob) ? '0 : r_wall_q;
                    r_res.position <= r_cur;
                    r_res.finished <= r_done;
                    r_res.fault    <= r_fault || (r_op == OP_READ && res_oob);
                    r_strobe       <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration beats; a new width invalidates the coordinates
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH: begin
                        r_cfg_w <= i_cfg_data;
                        r_stale <= 1'b1;
                    end
                    CFG_HEIGHT: begin
                        r_cfg_h <= i_cfg_data;
                    end
                    default: begin
                        r_cfg_h <= r_cfg_h;
                    end
                endcase
            end
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Checks
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result beat while a command is still running");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(MAX_CELLS))
        else $error("stack count beyond its depth");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state == S_FIN1_WR))
        else $error("finished set outside the opening cut");

endmodule
